/* src/sobl1_pkg.sv */
// ----------------------------------------------------------------------------
// sobl1_pkg
// Shared types and constants of the streaming Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobl1_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // input item codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // border-masked neighbourhood of one centre pixel, centre tap unused
  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tc;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] ml;
    logic [PIX_W-1:0] mr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] bc;
    logic [PIX_W-1:0] br;
    logic             last;
  } taps_t;

endpackage

/* src/sobl1_ram.sv */
// ----------------------------------------------------------------------------
// sobl1_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sobl1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/sobl1_div.sv */
// ----------------------------------------------------------------------------
// sobl1_div
// Restoring divider, one quotient bit per cycle. Splits the item counter
// into row and column after reset and after each register write.
// ----------------------------------------------------------------------------
module sobl1_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int SW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [SW-1:0]    step;
  logic [SW-1:0]    bit_sel;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  // operands stay still while busy: no item and no write is taken then
  always_comb begin
    bit_sel = SW'(DVD_W - 1) - step;
    rem_sh  = {remainder, dividend[bit_sel]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst || start) begin
      busy      <= 1'b1;
      step      <= '0;
      remainder <= '0;
      quotient  <= '0;
    end else if (busy) begin
      remainder <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quotient  <= DVD_W'({quotient, ge});
      if (step == SW'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

/* src/sobl1_grad.sv */
// ----------------------------------------------------------------------------
// sobl1_grad
// Tap register, Sobel gradient, L1 magnitude with clamp, output register.
// ----------------------------------------------------------------------------
module sobl1_grad (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  sobl1_pkg::taps_t        in_taps,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [sobl1_pkg::PIX_W-1:0] edge_magnitude,
  output logic                    frame_last
);

  sobl1_pkg::taps_t taps;
  logic             taps_valid;
  logic             out_load;
  logic [9:0]       pos_x, neg_x, pos_y, neg_y;
  logic [10:0]      gx, gy;
  logic [9:0]       abs_x, abs_y;
  logic [10:0]      mag;

  assign out_load = !out_valid || !out_stall;
  assign in_ready = !taps_valid || out_load;

  always_comb begin
    pos_x = 10'(taps.tr) + {1'b0, taps.mr, 1'b0} + 10'(taps.br);
    neg_x = 10'(taps.tl) + {1'b0, taps.ml, 1'b0} + 10'(taps.bl);
    pos_y = 10'(taps.bl) + {1'b0, taps.bc, 1'b0} + 10'(taps.br);
    neg_y = 10'(taps.tl) + {1'b0, taps.tc, 1'b0} + 10'(taps.tr);
    gx    = {1'b0, pos_x} - {1'b0, neg_x};
    gy    = {1'b0, pos_y} - {1'b0, neg_y};
    abs_x = gx[10] ? 10'(-gx) : gx[9:0];
    abs_y = gy[10] ? 10'(-gy) : gy[9:0];
    mag   = {1'b0, abs_x} + {1'b0, abs_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        taps_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= taps_valid;
      end
    end
    if (in_ready && in_valid) begin
      taps <= in_taps;
    end
    if (out_load && taps_valid) begin
      edge_magnitude <= (mag > 11'd255) ? 8'd255 : mag[7:0];
      frame_last     <= taps.last;
    end
  end

endmodule

/* src/sobel_l1_edge_magnitude.sv */
// ----------------------------------------------------------------------------
// sobel_l1_edge_magnitude
// Streaming 3x3 Sobel edge detector giving the clamped L1 gradient magnitude.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (op = pixel or flush), one
// transaction per cycle while in_stall is low; results leave on the out_
// channel. The result for a pixel comes with the item W+1 positions later
// and passes the stage 1, tap and output registers. After the frame W+1
// flush items push out the rest; the last result carries frame_last and the
// position counters restart. Both line buffers live in one RAM read and
// written back once per item at the current column, with write-to-read
// forwarding when a one-pixel row reuses the same entry on the next item.
// After reset and after every register write the item counter (23 bits at
// default sizes) is split into row and column by a one-bit-per-cycle divider.
// cfg_ready is low while the divider is busy; in_stall is high then and on
// the done cycle as the row and column load. The line buffers are never
// cleared; rows above the frame are masked. On a receiver stall the pipeline
// holds and in_stall rises in the same cycle once all stages are full.
// ----------------------------------------------------------------------------
module sobel_l1_edge_magnitude #(
  parameter int MAX_WIDTH  = sobl1_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobl1_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic [sobl1_pkg::PIX_W-1:0]     pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sobl1_pkg::PIX_W-1:0]     edge_magnitude,
  output logic                            frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sobl1_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sobl1_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PW  = sobl1_pkg::PIX_W;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int KW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);

  // configuration
  logic [sobl1_pkg::CFG_W-1:0] image_width, image_height;
  logic [WW-1:0]               w_eff;
  logic [HW-1:0]               h_eff;
  logic [KW-1:0]               last_k;
  logic                        cfg_write;

  // position counters
  logic [KW-1:0]  k, r;
  logic [CAW-1:0] c;

  // divider
  logic           busy, div_done;
  logic [KW-1:0]  div_quot;
  logic [WW-1:0]  div_rem;

  // item decode
  logic           accept;
  logic [PW-1:0]  d_in;
  logic           has_res, is_last, row_end;

  // stage 1
  logic           s1_valid, s1_res, s1_last;
  logic [CAW-1:0] s1_col;
  logic [PW-1:0]  s1_d;
  logic           s1_top_en, s1_mid_en, s1_mask_l, s1_mask_r;
  logic           s1_adv, s1_free;
  logic           grad_ready;

  // line buffer RAM: {two rows up, one row up}
  logic [2*PW-1:0] ram_rdata, ram_wdata, line;
  logic [2*PW-1:0] fwd_data;
  logic            fwd_valid;
  logic [PW-1:0]   top, mid;

  logic [PW-1:0]    win [9];
  sobl1_pkg::taps_t taps;

  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sobl1_pkg::CFG_W'(2048);
      image_height <= sobl1_pkg::CFG_W'(2048);
    end else if (cfg_write) begin
      case (cfg_index)
        sobl1_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        sobl1_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
    // frame end position settles while the divider runs
    if (busy) begin
      last_k <= KW'(32'(w_eff) * 32'(h_eff) + 32'(w_eff));
    end
  end

  sobl1_div #(
    .DVD_W (KW),
    .DVS_W (WW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_write),
    .dividend  (k),
    .divisor   (w_eff),
    .busy      (busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // ---- item decode -------------------------------------------------------
  assign s1_adv   = s1_valid && (!s1_res || grad_ready);
  assign s1_free  = !s1_valid || s1_adv;
  // row and column load on the done cycle, so no transaction is taken then
  assign in_stall = busy || div_done || !s1_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    d_in    = (op == sobl1_pkg::OP_PIXEL && 32'(r) < 32'(h_eff)) ? pixel : '0;
    has_res = 32'(k) > 32'(w_eff);
    is_last = has_res && (k >= last_k);
    row_end = (32'(c) + 1) == 32'(w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      r <= '0;
      c <= '0;
    end else if (div_done) begin
      r <= div_quot;
      c <= div_rem[CAW-1:0];
    end else if (accept) begin
      if (is_last) begin
        k <= '0;
        r <= '0;
        c <= '0;
      end else begin
        k <= k + 1'b1;
        if (row_end) begin
          c <= '0;
          r <= r + 1'b1;
        end else begin
          c <= c + 1'b1;
        end
      end
    end
  end

  // ---- stage 1: line buffer read-modify-write, window shift --------------
  sobl1_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (c),
    .rdata (ram_rdata)
  );

  always_comb begin
    line      = fwd_valid ? fwd_data : ram_rdata;
    ram_wdata = {line[PW-1:0], s1_d};
    top       = s1_top_en ? line[2*PW-1:PW] : '0;
    mid       = s1_mid_en ? line[PW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (s1_free) begin
        s1_valid <= accept;
      end
      if (accept) begin
        // same entry written while read: the RAM returns the stale word
        fwd_valid <= s1_adv && (s1_col == c);
      end
      if (s1_adv) begin
        for (int row = 0; row < 3; row++) begin
          win[row*3]     <= win[row*3 + 1];
          win[row*3 + 1] <= win[row*3 + 2];
        end
        win[2] <= top;
        win[5] <= mid;
        win[8] <= s1_d;
      end
    end
    if (accept) begin
      fwd_data  <= ram_wdata;
      s1_col    <= c;
      s1_d      <= d_in;
      s1_res    <= has_res;
      s1_last   <= is_last;
      s1_top_en <= r >= KW'(2);
      s1_mid_en <= r != '0;
      s1_mask_l <= (c == CAW'(1)) || (c == '0 && w_eff == WW'(1));
      s1_mask_r <= c == '0;
    end
  end

  // taps of the window as it stands after this shift
  always_comb begin
    taps.tl   = s1_mask_l ? '0 : win[1];
    taps.ml   = s1_mask_l ? '0 : win[4];
    taps.bl   = s1_mask_l ? '0 : win[7];
    taps.tc   = win[2];
    taps.bc   = win[8];
    taps.tr   = s1_mask_r ? '0 : top;
    taps.mr   = s1_mask_r ? '0 : mid;
    taps.br   = s1_mask_r ? '0 : s1_d;
    taps.last = s1_last;
  end

  sobl1_grad u_grad (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s1_adv && s1_res),
    .in_taps        (taps),
    .in_ready       (grad_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_magnitude (edge_magnitude),
    .frame_last     (frame_last)
  );

endmodule
